[rtl/core/assert_macros.svh]
// Assertion macros shared by the core RTL.
// TNSC_ASSERT checks on every rising clk edge outside reset.
// TNSC_ASSERT_RST checks on every rising clk edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define TNSC_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TNSC_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define TNSC_ASSERT(name, prop)
`define TNSC_ASSERT_RST(name, prop)
`endif

`endif

[rtl/core/tnsc_pkg.sv]
`default_nettype none

package tnsc_pkg;

  localparam int SPEED_W = 15;
  localparam int BRAKE_W = 4;
  localparam int POWER_W = 3;
  localparam int IN_BITS = 8;

  localparam int SPEED_FRAC_BITS_DEF = 8;
  localparam int DUTY_BITS_DEF       = 10;

  localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
  localparam int LIMIT_TOP = 110;

  // notch codes
  localparam logic [BRAKE_W-1:0] BRAKE_RELEASED  = 4'd0;
  localparam logic [BRAKE_W-1:0] BRAKE_UNKNOWN   = 4'd9;
  localparam logic [BRAKE_W-1:0] BRAKE_EMERGENCY = 4'd10;
  localparam logic [POWER_W-1:0] POWER_OFF       = 3'd0;

  localparam int BRAKE_CODES = 2 ** BRAKE_W;
  localparam int POWER_CODES = 2 ** POWER_W;

  typedef struct packed {
    logic [BRAKE_W-1:0] brake;
    logic [POWER_W-1:0] power;
  } notch_t;

  // raw contact code -> notch
  localparam logic [BRAKE_W-1:0] BRAKE_CODE_TAB [BRAKE_CODES] = '{
    4'd9, 4'd3, 4'd0, 4'd4, 4'd7, 4'd9, 4'd8, 4'd9,
    4'd1, 4'd5, 4'd2, 4'd6, 4'd9, 4'd9, 4'd9, 4'd10
  };
  localparam logic [POWER_W-1:0] POWER_CODE_TAB [POWER_CODES] = '{
    3'd0, 3'd0, 3'd3, 3'd4, 3'd1, 3'd2, 3'd5, 3'd0
  };

  // per-tick steps in km/h as exact ratios; unused notches are zero
  localparam int ACC_NUM [POWER_CODES] = '{0, 3, 1, 3, 15, 3, 0, 0};
  localparam int ACC_DEN [POWER_CODES] = '{1, 10, 2, 4, 13, 2, 1, 1};
  localparam int LIM_NUM [POWER_CODES] = '{0, 55, 55, 220, 110, 110, 0, 0};
  localparam int LIM_DEN [POWER_CODES] = '{1, 2, 1, 3, 1, 1, 1, 1};

  // entry 0 coasting drag, 1..8 service brake, 9 unknown, rest unused
  localparam int DEC_NUM [BRAKE_CODES] = '{
    1, 5, 2, 10, 5, 50, 20, 25, 100, 10, 0, 0, 0, 0, 0, 0
  };
  localparam int DEC_DEN [BRAKE_CODES] = '{
    6, 12, 3, 9, 3, 27, 9, 9, 33, 3, 1, 1, 1, 1, 1, 1
  };

endpackage

`default_nettype wire

[rtl/core/tnsc_notch_decode.sv]
`default_nettype none

// Handle contacts to notches; power is only read with the brake released.
module tnsc_notch_decode (
  input  wire logic [tnsc_pkg::BRAKE_W-1:0] brake_switches,
  input  wire logic [tnsc_pkg::POWER_W-1:0] power_switches,
  output tnsc_pkg::notch_t                   notch
);

  always_comb begin
    notch.brake = tnsc_pkg::BRAKE_CODE_TAB[brake_switches];
    if (notch.brake == tnsc_pkg::BRAKE_RELEASED) begin
      notch.power = tnsc_pkg::POWER_CODE_TAB[power_switches];
    end else begin
      notch.power = tnsc_pkg::POWER_OFF;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tnsc_speed_update.sv]
`default_nettype none

`include "assert_macros.svh"

// Speed accumulator: a table step up or down per word, floored, saturated.
module tnsc_speed_update #(
  parameter int SPEED_FRAC_BITS = tnsc_pkg::SPEED_FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire tnsc_pkg::notch_t             notch_in,
  output logic [tnsc_pkg::SPEED_W-1:0]      speed_o,
  output tnsc_pkg::notch_t                  notch_o
);

  localparam int SW    = tnsc_pkg::SPEED_W;
  // largest limit is 110 km/h, below 2^(7+F)
  localparam int LIM_W = 7 + SPEED_FRAC_BITS;
  localparam int CMP_W = (LIM_W > SW) ? LIM_W : SW;

  logic [SW-1:0]    acc_step [tnsc_pkg::POWER_CODES];
  logic [CMP_W-1:0] lim_thr  [tnsc_pkg::POWER_CODES];
  logic [SW-1:0]    dec_step [tnsc_pkg::BRAKE_CODES];

  // steps rounded half up; limit s < n/d turned into s < ceil(n*2^F/d)
  for (genvar i = 0; i < tnsc_pkg::POWER_CODES; i++) begin : g_power
    localparam longint unsigned AN = longint'(tnsc_pkg::ACC_NUM[i]);
    localparam longint unsigned AD = longint'(tnsc_pkg::ACC_DEN[i]);
    localparam longint unsigned LN = longint'(tnsc_pkg::LIM_NUM[i]);
    localparam longint unsigned LD = longint'(tnsc_pkg::LIM_DEN[i]);
    localparam longint unsigned AV = ((AN << (SPEED_FRAC_BITS + 1)) + AD) / (2 * AD);
    localparam longint unsigned LV = ((LN << SPEED_FRAC_BITS) + LD - 1) / LD;
    assign acc_step[i] = SW'(AV);
    assign lim_thr[i]  = CMP_W'(LV);
  end

  for (genvar i = 0; i < tnsc_pkg::BRAKE_CODES; i++) begin : g_brake
    localparam longint unsigned DN = longint'(tnsc_pkg::DEC_NUM[i]);
    localparam longint unsigned DD = longint'(tnsc_pkg::DEC_DEN[i]);
    localparam longint unsigned DV = ((DN << (SPEED_FRAC_BITS + 1)) + DD) / (2 * DD);
    assign dec_step[i] = SW'(DV);
  end

  logic [SW-1:0]    speed_r, speed_nxt;
  tnsc_pkg::notch_t notch_r;
  logic [SW-1:0]    acc, dec;
  logic [SW:0]      sum;

  always_comb begin
    acc = '0;
    dec = '0;
    if (notch_in.brake == tnsc_pkg::BRAKE_RELEASED) begin
      if (notch_in.power == tnsc_pkg::POWER_OFF) begin
        dec = dec_step[0];
      end else if (CMP_W'(speed_r) < lim_thr[notch_in.power]) begin
        acc = acc_step[notch_in.power];
      end
    end else begin
      dec = dec_step[notch_in.brake];
    end

    // acc and dec are never both nonzero
    sum = {1'b0, speed_r} + {1'b0, acc};
    if (notch_in.brake == tnsc_pkg::BRAKE_EMERGENCY) begin
      speed_nxt = '0;
    end else if (sum > {1'b0, tnsc_pkg::SPEED_MAX}) begin
      speed_nxt = tnsc_pkg::SPEED_MAX;
    end else if (sum < {1'b0, dec}) begin
      speed_nxt = '0;
    end else begin
      speed_nxt = SW'(sum - {1'b0, dec});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
    end else if (load) begin
      speed_r <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      notch_r <= notch_in;
    end
  end

  assign speed_o = speed_r;
  assign notch_o = notch_r;

  `TNSC_ASSERT(a_speed_hold, !load |=> $stable(speed_r))

endmodule

`default_nettype wire

[rtl/core/tnsc_duty.sv]
`default_nettype none

// Result register: duty = floor(speed * FULL / (110 * 2^F)) via one
// reciprocal multiply, saturated at FULL.
module tnsc_duty #(
  parameter int SPEED_FRAC_BITS = tnsc_pkg::SPEED_FRAC_BITS_DEF,
  parameter int DUTY_BITS       = tnsc_pkg::DUTY_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        load,
  input  wire logic [tnsc_pkg::SPEED_W-1:0] speed_in,
  input  wire tnsc_pkg::notch_t            notch_in,
  output logic [tnsc_pkg::SPEED_W-1:0]     speed_o,
  output logic [DUTY_BITS-1:0]             duty_o,
  output tnsc_pkg::notch_t                 notch_o
);

  localparam int SW = tnsc_pkg::SPEED_W;
  localparam longint unsigned FULL = (longint'(1) << DUTY_BITS) - 1;
  localparam longint unsigned DIV  = longint'(tnsc_pkg::LIMIT_TOP) << SPEED_FRAC_BITS;
  // 2^K >= 2^SW * DIV keeps the rounded-up reciprocal exact over the speed range
  localparam int K  = SW + $clog2(DIV);
  localparam longint unsigned RECIP = ((FULL << K) + DIV - 1) / DIV;
  localparam int MW = DUTY_BITS + 16;
  localparam int PW = SW + MW;

  logic [MW-1:0]        recip;
  logic [PW-1:0]        prod, quot;
  logic [DUTY_BITS-1:0] duty_nxt;
  logic [SW-1:0]        speed_r;
  logic [DUTY_BITS-1:0] duty_r;
  tnsc_pkg::notch_t     notch_r;

  assign recip = MW'(RECIP);

  always_comb begin
    prod = PW'(speed_in) * PW'(recip);
    quot = prod >> K;
    if (quot > PW'(FULL)) begin
      duty_nxt = DUTY_BITS'(FULL);
    end else begin
      duty_nxt = quot[DUTY_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      speed_r <= speed_in;
      duty_r  <= duty_nxt;
      notch_r <= notch_in;
    end
  end

  assign speed_o = speed_r;
  assign duty_o  = duty_r;
  assign notch_o = notch_r;

endmodule

`default_nettype wire

[rtl/core/train_notch_speed_controller_core.sv]
// Train notch speed controller core.
// Input stream (in_*): one word per control tick with the raw brake-handle
// and power-handle contacts. Output stream (out_*): one word per input word
// with the updated speed (Q7.8 km/h by default), motor PWM duty, and the
// decoded power and brake notches. No configuration port.
// Pipeline: input register -> notch decode and speed update -> duty
// multiply into the output register (three register stages); a word
// passes them in that order to out_*. Throughput is one word per cycle
// while out_tready is high; the speed accumulator is updated by a single
// table step and add, so consecutive words chain through it without bubbles.
// Reset (rst_n low, synchronous) empties all stages and clears the speed
// to 0. When out_tready is low the output word holds and the two stages
// behind it keep filling; in_tready drops only once all three are full.
`default_nettype none

`include "assert_macros.svh"

module train_notch_speed_controller_core #(
  parameter int SPEED_FRAC_BITS = tnsc_pkg::SPEED_FRAC_BITS_DEF,
  parameter int DUTY_BITS       = tnsc_pkg::DUTY_BITS_DEF,
  localparam int OUT_BITS = ((tnsc_pkg::SPEED_W + DUTY_BITS + tnsc_pkg::POWER_W
                              + tnsc_pkg::BRAKE_W + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // [3:0] brake_switches, [6:4] power_switches, [7] zero
  input  wire logic [tnsc_pkg::IN_BITS-1:0] in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // from bit 0: scale_speed (15), pwm_duty (DUTY_BITS), power_level (3),
  // brake_level (4), zero fill to a whole byte
  output logic [OUT_BITS-1:0]               out_tdata
);

  localparam int SW = tnsc_pkg::SPEED_W;
  localparam int BW = tnsc_pkg::BRAKE_W;
  localparam int PWR_W = tnsc_pkg::POWER_W;
  localparam longint unsigned FULL = (longint'(1) << DUTY_BITS) - 1;
  localparam longint unsigned DIV  = longint'(tnsc_pkg::LIMIT_TOP) << SPEED_FRAC_BITS;

  // stage valids
  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic s3_v_r, s3_v_nxt;
  logic adv2, adv3, load1, load2, load3;

  // input register
  logic [BW-1:0]    brake_r;
  logic [PWR_W-1:0] power_r;

  tnsc_pkg::notch_t     notch_dec, notch_s2, notch_res;
  logic [SW-1:0]        speed_s2, speed_res;
  logic [DUTY_BITS-1:0] duty_res;

  assign adv3      = !s3_v_r || out_tready;
  assign adv2      = !s2_v_r || adv3;
  assign in_tready = !s1_v_r || adv2;
  assign load1     = in_tvalid && in_tready;
  assign load2     = s1_v_r && adv2;
  assign load3     = s2_v_r && adv3;

  always_comb begin
    s1_v_nxt = s1_v_r;
    s2_v_nxt = s2_v_r;
    s3_v_nxt = s3_v_r;
    if (in_tready) begin
      s1_v_nxt = in_tvalid;
    end
    if (adv2) begin
      s2_v_nxt = s1_v_r;
    end
    if (adv3) begin
      s3_v_nxt = s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      brake_r <= in_tdata[BW-1:0];
      power_r <= in_tdata[BW+PWR_W-1:BW];
    end
  end

  tnsc_notch_decode u_decode (
    .brake_switches (brake_r),
    .power_switches (power_r),
    .notch          (notch_dec)
  );

  tnsc_speed_update #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS)
  ) u_speed (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (load2),
    .notch_in (notch_dec),
    .speed_o  (speed_s2),
    .notch_o  (notch_s2)
  );

  tnsc_duty #(
    .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
    .DUTY_BITS       (DUTY_BITS)
  ) u_duty (
    .clk      (clk),
    .load     (load3),
    .speed_in (speed_s2),
    .notch_in (notch_s2),
    .speed_o  (speed_res),
    .duty_o   (duty_res),
    .notch_o  (notch_res)
  );

  assign out_tvalid = s3_v_r;
  assign out_tdata  = OUT_BITS'({notch_res.brake, notch_res.power, duty_res, speed_res});

  // emergency stops the train within the same tick
  `TNSC_ASSERT(a_emergency_stop,
    load2 && notch_dec.brake == tnsc_pkg::BRAKE_EMERGENCY |=> speed_s2 == '0)
  // full duty exactly at and above the top speed
  `TNSC_ASSERT(a_duty_full,
    out_tvalid |-> ((duty_res == DUTY_BITS'(FULL)) == (longint'(speed_res) >= DIV)))
  // power is only reported with the brake released
  `TNSC_ASSERT(a_power_gated,
    out_tvalid && notch_res.power != tnsc_pkg::POWER_OFF
      |-> notch_res.brake == tnsc_pkg::BRAKE_RELEASED)
  `TNSC_ASSERT_RST(a_reset_empty, !rst_n |=> !out_tvalid && !s1_v_r && !s2_v_r)

endmodule

`default_nettype wire
